// ===== design/qvr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared types and constants for the quaternion vector rotation unit.
// ----------------------------------------------------------------------------
package qvr_pkg;

   // field widths
   localparam int QUAT_W   = 16;
   localparam int VEC_W    = 32;
   localparam int CSR_IDX_W = 4;

   // internal widths
   localparam int SPLIT_BITS = 24;                      // low slice of the cross product
   localparam int AV_W       = QUAT_W + VEC_W;          // a * v product
   localparam int CROSS_W    = AV_W + 1;                // a x v difference
   localparam int HI_W       = CROSS_W - SPLIT_BITS;    // signed high slice
   localparam int PROD_W     = QUAT_W + HI_W;           // quaternion times slice
   localparam int SUM_W      = 48;                      // partial sums and final total
   localparam int FRAC_DROP  = 3;                       // 2^-19 units down to Q16.16
   localparam int ROUND_BIT  = 26;                      // half of one output lsb, 2^-43 units

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_QUAT_REAL = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUAT_I    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUAT_J    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_QUAT_K    = 4'd3;

   // register reset values, Q2.14
   localparam logic signed [QUAT_W-1:0] QUAT_REAL_RESET = 16'sd16384;
   localparam logic signed [QUAT_W-1:0] QUAT_IMAG_RESET = 16'sd0;

   // pipeline depth from accept to result strobe
   localparam int PIPE_DEPTH = 5;

   typedef struct packed {
      logic signed [VEC_W-1:0] vec_x;
      logic signed [VEC_W-1:0] vec_y;
      logic signed [VEC_W-1:0] vec_z;
   } req_data_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] rot_x;
      logic signed [VEC_W-1:0] rot_y;
      logic signed [VEC_W-1:0] rot_z;
   } rsp_data_type;

endpackage

// ===== design/quaternion_vector_rotate_unit.sv =====
`timescale 1ns / 1ps
// Path: an accepted beat moves through stages s1 to s5; rsp_valid is the stage 5 valid bit.
// Throughput: one vector per cycle; five register stages of multiply and add,
// the receiver cannot stall so busy never rises.
// Reset: synchronous, active high; clears the stage valid bits and loads the
// quaternion registers with the identity rotation (real part 1.0).
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit
// Rotates a Q16.16 vector by the Q2.14 quaternion in the CSRs using
// t = 2(a x v), v' = v + w t + a x t, rounded and saturated to Q16.16.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_unit
   import qvr_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // command side
   input  logic                        start,
   output logic                        busy,
   input  req_data_type                req_data,
   // result side
   output logic                        rsp_valid,
   output rsp_data_type                rsp_data,
   // register write port
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic signed [QUAT_W-1:0]    csr_data
);

   // quaternion registers
   logic signed [QUAT_W-1:0] quat_real_ff, quat_i_ff, quat_j_ff, quat_k_ff;
   logic signed [QUAT_W-1:0] quat_a [3];

   // pipeline never stalls
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // register writes, unknown index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         quat_real_ff <= QUAT_REAL_RESET;
         quat_i_ff    <= QUAT_IMAG_RESET;
         quat_j_ff    <= QUAT_IMAG_RESET;
         quat_k_ff    <= QUAT_IMAG_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_QUAT_REAL: quat_real_ff <= csr_data;
            CSR_QUAT_I:    quat_i_ff    <= csr_data;
            CSR_QUAT_J:    quat_j_ff    <= csr_data;
            CSR_QUAT_K:    quat_k_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   assign quat_a[0] = quat_i_ff;
   assign quat_a[1] = quat_j_ff;
   assign quat_a[2] = quat_k_ff;

   // incoming beat
   logic                    accept;
   logic signed [VEC_W-1:0] vec_in [3];

   assign accept    = start && !busy;
   assign vec_in[0] = req_data.vec_x;
   assign vec_in[1] = req_data.vec_y;
   assign vec_in[2] = req_data.vec_z;

   // stage valid bits
   logic valid_s1_ff, valid_s2_ff, valid_s3_ff, valid_s4_ff, valid_s5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
         valid_s2_ff <= 1'b0;
         valid_s3_ff <= 1'b0;
         valid_s4_ff <= 1'b0;
         valid_s5_ff <= 1'b0;
      end else begin
         valid_s1_ff <= accept;
         valid_s2_ff <= valid_s1_ff;
         valid_s3_ff <= valid_s2_ff;
         valid_s4_ff <= valid_s3_ff;
         valid_s5_ff <= valid_s4_ff;
      end
   end

   // vector carried down to the final sum
   logic signed [VEC_W-1:0] vec_s1_ff [3];
   logic signed [VEC_W-1:0] vec_s2_ff [3];
   logic signed [VEC_W-1:0] vec_s3_ff [3];

   // stage data
   logic signed [AV_W-1:0]    av_p_s1_ff   [3];
   logic signed [AV_W-1:0]    av_q_s1_ff   [3];
   logic signed [CROSS_W-1:0] cross_s2_ff  [3];
   logic signed [PROD_W-1:0]  whi_s3_ff    [3];
   logic signed [PROD_W-1:0]  phi_s3_ff    [3];
   logic signed [PROD_W-1:0]  qhi_s3_ff    [3];
   logic signed [PROD_W-1:0]  wlo_s3_ff    [3];
   logic signed [PROD_W-1:0]  plo_s3_ff    [3];
   logic signed [PROD_W-1:0]  qlo_s3_ff    [3];
   logic signed [SUM_W-1:0]   hi_sum_s4_ff [3];
   logic signed [SUM_W-1:0]   lo_sum_s4_ff [3];
   logic signed [VEC_W-1:0]   rot_s5_ff    [3];

   // high and low slices of the cross product, extended for the products
   logic signed [PROD_W-1:0] hi_ext [3];
   logic signed [PROD_W-1:0] lo_ext [3];

   for (genvar n = 0; n < 3; n++) begin : g_slice
      assign hi_ext[n] = PROD_W'($signed(cross_s2_ff[n][CROSS_W-1:SPLIT_BITS]));
      assign lo_ext[n] = $signed(PROD_W'(cross_s2_ff[n][SPLIT_BITS-1:0]));
   end

   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-64'sd2147483648);

   for (genvar n = 0; n < 3; n++) begin : g_lane
      localparam int P = (n + 1) % 3;
      localparam int Q = (n + 2) % 3;

      // operands extended to product width
      logic signed [AV_W-1:0]   ap_av, aq_av, vq_av, vp_av;
      logic signed [PROD_W-1:0] w_pr, ap_pr, aq_pr;
      logic signed [SUM_W-1:0]  hi_sum_in, lo_sum_in, total, shifted;

      assign ap_av = AV_W'(quat_a[P]);
      assign aq_av = AV_W'(quat_a[Q]);
      assign vq_av = AV_W'(vec_in[Q]);
      assign vp_av = AV_W'(vec_in[P]);
      assign w_pr  = PROD_W'(quat_real_ff);
      assign ap_pr = PROD_W'(quat_a[P]);
      assign aq_pr = PROD_W'(quat_a[Q]);

      // stage 1: the two products of a x v
      always_ff @(posedge clock) begin
         av_p_s1_ff[n] <= ap_av * vq_av;
         av_q_s1_ff[n] <= aq_av * vp_av;
         vec_s1_ff[n]  <= vec_in[n];
      end

      // stage 2: cross product component
      always_ff @(posedge clock) begin
         cross_s2_ff[n] <= CROSS_W'(av_p_s1_ff[n]) - CROSS_W'(av_q_s1_ff[n]);
         vec_s2_ff[n]   <= vec_s1_ff[n];
      end

      // stage 3: w*c and a x c on both slices
      always_ff @(posedge clock) begin
         whi_s3_ff[n] <= w_pr  * hi_ext[n];
         phi_s3_ff[n] <= ap_pr * hi_ext[Q];
         qhi_s3_ff[n] <= aq_pr * hi_ext[P];
         wlo_s3_ff[n] <= w_pr  * lo_ext[n];
         plo_s3_ff[n] <= ap_pr * lo_ext[Q];
         qlo_s3_ff[n] <= aq_pr * lo_ext[P];
         vec_s3_ff[n] <= vec_s2_ff[n];
      end

      // stage 4: high and low partial sums, rounding constant on the low side
      assign hi_sum_in = (SUM_W'(vec_s3_ff[n]) <<< FRAC_DROP)
                       + SUM_W'(whi_s3_ff[n]) + SUM_W'(phi_s3_ff[n])
                       - SUM_W'(qhi_s3_ff[n]);
      assign lo_sum_in = SUM_W'(wlo_s3_ff[n]) + SUM_W'(plo_s3_ff[n])
                       - SUM_W'(qlo_s3_ff[n])
                       + (SUM_W'(1) <<< ROUND_BIT);

      always_ff @(posedge clock) begin
         hi_sum_s4_ff[n] <= hi_sum_in;
         lo_sum_s4_ff[n] <= lo_sum_in;
      end

      // stage 5: merge, drop fraction, saturate
      assign total   = hi_sum_s4_ff[n] + (lo_sum_s4_ff[n] >>> SPLIT_BITS);
      assign shifted = total >>> FRAC_DROP;

      always_ff @(posedge clock) begin
         priority if (shifted > SAT_MAX) begin
            rot_s5_ff[n] <= SAT_MAX[VEC_W-1:0];
         end else if (shifted < SAT_MIN) begin
            rot_s5_ff[n] <= SAT_MIN[VEC_W-1:0];
         end else begin
            rot_s5_ff[n] <= shifted[VEC_W-1:0];
         end
      end
   end

   // result beat
   assign rsp_valid      = valid_s5_ff;
   assign rsp_data.rot_x = rot_s5_ff[0];
   assign rsp_data.rot_y = rot_s5_ff[1];
   assign rsp_data.rot_z = rot_s5_ff[2];

`ifndef NO_ASSERTIONS
   // every result beat comes from an earlier accepted beat
   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, PIPE_DEPTH))
      else $error("result beat without a matching command");

   // every accepted beat gives a result beat
   a_cmd_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_DEPTH rsp_valid)
      else $error("accepted command lost in the pipeline");

   // quaternion comes out of reset as the identity
   a_quat_reset: assert property (@(posedge clock)
      $past(reset) |-> (quat_real_ff == QUAT_REAL_RESET && quat_i_ff == QUAT_IMAG_RESET
                        && quat_j_ff == QUAT_IMAG_RESET && quat_k_ff == QUAT_IMAG_RESET))
      else $error("quaternion registers not at reset value");
`endif

endmodule
